### src/bkm_pkg.sv
`default_nettype none
package bkm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int ERRORS_MAX  = 8;
  localparam int VEC_W       = PATTERN_MAX + 1;
  localparam int LEN_W       = 6;
  localparam int ERR_W       = 4;
  localparam int POS_W       = 5;
  localparam int CHAR_W      = 8;
  localparam int COUNT_W     = 32;
  localparam int CFG_DATA_W  = 6;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_TEXT    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic CFG_PATTERN_LENGTH = 1'b0;
  localparam logic CFG_MAX_ERRORS     = 1'b1;

  localparam logic [VEC_W-1:0] VEC_INIT = {{(VEC_W-1){1'b1}}, 1'b0};

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [ERR_W-1:0] k;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [VEC_W-1:0] mask;
    logic             eot;
  } entry_t;

endpackage
`default_nettype wire

### src/bitap_k_mismatch_matcher.sv
// bitap matcher, shift-or with up to max_errors substitutions (hamming distance)
// input stream s_*: one transaction per item; opcode selects load pattern byte,
// text byte or restart; s_tlast carries end_of_text
// output stream m_*: exactly one result transaction per input item, in order;
// match flag, saturating match count, m_tlast echoes end_of_text on text bytes
// config port: cfg_we writes cfg_data to register cfg_index
// (0 pattern_length, 1 max_errors); write only while the block is idle
// latency: two cycles, one in the queue and one in the output register; the
// result is valid from the second rising edge after the input is accepted
// throughput: one item per cycle, set by the single-cycle update of all
// error levels in parallel in the back end
// a two-entry queue sits between the classifying front end and the back end;
// when m_tready is low the output register holds, the queue fills and
// s_tready falls once both entries are taken
// reset: pattern_length 1, max_errors 0, vectors all ones except bit zero,
// count zero; pattern bytes are undefined until loaded
`default_nettype none
module bitap_k_mismatch_matcher (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // opcode[1:0], position[6:2], character[14:7], zero[15]
  input  wire logic [15:0]                    s_tdata,
  // end_of_text
  input  wire logic                           s_tlast,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // match[0], match_count[32:1], zero[39:33]
  output logic [39:0]                         m_tdata,
  // done_res
  output logic                                m_tlast,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [bkm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bkm_pkg::*;

  logic [LEN_W-1:0] pattern_length;
  logic [ERR_W-1:0] max_errors;
  cfg_t             cfg;
  entry_t           push_entry;
  entry_t           pop_entry;
  logic             full;
  logic             empty;
  logic             push;
  logic             pop;
  logic             back_ready;
  logic             out_match;
  logic [31:0]      out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      max_errors     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        CFG_MAX_ERRORS:     max_errors     <= cfg_data[ERR_W-1:0];
        default:            pattern_length <= pattern_length;
      endcase
    end
  end

  assign cfg.len = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                            : pattern_length;
  assign cfg.k   = (max_errors > ERR_W'(ERRORS_MAX)) ? ERR_W'(ERRORS_MAX) : max_errors;

  assign s_tready = !full;
  assign push     = s_tvalid && !full;
  assign pop      = !empty && back_ready;

  bkm_front u_front (
    .clk         (clk),
    .accept      (push),
    .opcode      (s_tdata[1:0]),
    .position    (s_tdata[6:2]),
    .character   (s_tdata[14:7]),
    .end_of_text (s_tlast),
    .cfg         (cfg),
    .entry       (push_entry)
  );

  bkm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (empty)
  );

  bkm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop       (pop),
    .entry     (pop_entry),
    .ready     (back_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_match (out_match),
    .out_count (out_count),
    .out_done  (m_tlast)
  );

  assign m_tdata = {7'd0, out_count, out_match};

endmodule
`default_nettype wire

### src/bkm_front.sv
`default_nettype none
module bkm_front (
  input  wire logic                   clk,
  input  wire logic                   accept,
  input  wire logic [1:0]             opcode,
  input  wire logic [4:0]             position,
  input  wire logic [7:0]             character,
  input  wire logic                   end_of_text,
  input  wire bkm_pkg::cfg_t          cfg,
  output bkm_pkg::entry_t             entry
);
  import bkm_pkg::*;

  logic [CHAR_W-1:0] store [PATTERN_MAX];
  logic [VEC_W-1:0]  mask;

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_LOAD && {1'b0, position} < LEN_W'(PATTERN_MAX)) begin
      store[position] <= character;
    end
  end

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      mask[i] = !((LEN_W'(i) < cfg.len) && (store[i] == character));
    end
    mask[PATTERN_MAX] = 1'b1;
  end

  assign entry.op   = opcode;
  assign entry.mask = mask;
  assign entry.eot  = end_of_text;

endmodule
`default_nettype wire

### src/bkm_queue.sv
`default_nettype none
module bkm_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bkm_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output bkm_pkg::entry_t      pop_entry,
  output logic                 empty
);
  import bkm_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign empty     = (count == 2'd0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

### src/bkm_back.sv
`default_nettype none
module bkm_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bkm_pkg::cfg_t   cfg,
  input  wire logic            pop,
  input  wire bkm_pkg::entry_t entry,
  output logic                 ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_match,
  output logic [31:0]          out_count,
  output logic                 out_done
);
  import bkm_pkg::*;

  logic [VEC_W-1:0]   vec      [ERRORS_MAX+1];
  logic [VEC_W-1:0]   vec_next [ERRORS_MAX+1];
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               match_next;

  assign ready = !out_valid || out_ready;

  always_comb begin
    vec_next[0] = (vec[0] | entry.mask) << 1;
    for (int j = 1; j <= ERRORS_MAX; j++) begin
      vec_next[j] = ((vec[j] | entry.mask) & vec[j-1]) << 1;
    end
    match_next = (entry.op == OP_TEXT) && !vec_next[cfg.k][cfg.len];
    case (entry.op)
      OP_RESTART: count_next = '0;
      OP_TEXT:    count_next = (match_next && count != '1) ? count + 1'b1 : count;
      default:    count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= ERRORS_MAX; j++) begin
        vec[j] <= VEC_INIT;
      end
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        count     <= count_next;
        out_valid <= 1'b1;
        if (entry.op == OP_TEXT) begin
          for (int j = 0; j <= ERRORS_MAX; j++) begin
            vec[j] <= vec_next[j];
          end
        end else if (entry.op == OP_RESTART) begin
          for (int j = 0; j <= ERRORS_MAX; j++) begin
            vec[j] <= VEC_INIT;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_match <= match_next;
      out_count <= count_next;
      out_done  <= (entry.op == OP_TEXT) && entry.eot;
    end
  end

`ifndef SYNTH
  a_vec_bit0_low: assert property (@(posedge clk) disable iff (rst)
    !vec[0][0] && !vec[ERRORS_MAX][0])
    else $error("error vector bit zero set");
  a_match_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_match) |-> (out_count != '0))
    else $error("match reported with zero count");
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && entry.op == OP_RESTART) |=> (count == '0 && out_count == '0))
    else $error("restart did not clear count");
  a_pop_only_ready: assert property (@(posedge clk) disable iff (rst)
    pop |-> ready)
    else $error("pop while output stalled");
`endif

endmodule
`default_nettype wire
